### design/tcs_pkg.sv
// ----------------------------------------------------------------------------
// Thermal cycle sequencer package
// Field widths, register indexes, phase and final action codes.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int TEMP_W   = 13;
    localparam int DRIVE_W  = 9;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 16;
    localparam int DUTY_W   = 8;
    localparam int COUNT_W  = 8;
    localparam int MODE_W   = 4;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [TEMP_W-1:0]  t_temp;
    typedef logic signed [DRIVE_W-1:0] t_drive;
    typedef logic [TIME_W-1:0]         t_time;
    typedef logic [HOLD_W-1:0]         t_hold;
    typedef logic [DUTY_W-1:0]         t_duty;
    typedef logic [COUNT_W-1:0]        t_count;
    typedef logic [MODE_W-1:0]         t_mode;
    typedef logic [PHASE_W-1:0]        t_phase;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]     t_cfg_data;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_BASE_TEMP      = 4'd0;
    localparam t_cfg_idx CFG_TOP_TEMP       = 4'd1;
    localparam t_cfg_idx CFG_BOTTOM_TEMP    = 4'd2;
    localparam t_cfg_idx CFG_BASE_HOLD_MS   = 4'd3;
    localparam t_cfg_idx CFG_TOP_HOLD_MS    = 4'd4;
    localparam t_cfg_idx CFG_BOTTOM_HOLD_MS = 4'd5;
    localparam t_cfg_idx CFG_CYCLE_TARGET   = 4'd6;
    localparam t_cfg_idx CFG_CONTROL_MODE   = 4'd7;

    // Phase codes reported with every result word.
    localparam t_phase PH_BASE   = 3'd0;
    localparam t_phase PH_TOP    = 3'd1;
    localparam t_phase PH_BOTTOM = 3'd2;
    localparam t_phase PH_FINAL  = 3'd3;
    localparam t_phase PH_MANUAL = 3'd4;

    // Final action codes, control_mode bits 2:1.
    localparam logic [1:0] FIN_HOLD_BASE   = 2'd0;
    localparam logic [1:0] FIN_HOLD_BOTTOM = 2'd1;
    localparam logic [1:0] FIN_HOLD_TOP    = 2'd2;
    localparam logic [1:0] FIN_ALL_OFF     = 2'd3;

    // Reset values of the configuration registers.
    localparam t_temp  RST_BASE_TEMP    = 13'sd400;
    localparam t_temp  RST_TOP_TEMP     = 13'sd1520;
    localparam t_temp  RST_BOTTOM_TEMP  = 13'sd960;
    localparam t_hold  RST_HOLD_MS      = 16'd1000;
    localparam t_count RST_CYCLE_TARGET = 8'd30;
    localparam t_mode  RST_CONTROL_MODE = 4'd1;
    localparam t_temp  RST_SETPOINT     = 13'sd400;

    localparam t_duty DUTY_FULL = 8'd255;
    localparam t_duty DUTY_OFF  = 8'd0;

endpackage

### design/tcs_if.sv
// ----------------------------------------------------------------------------
// Thermal cycle sequencer channels
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tcs_in_if;
    import tcs_pkg::*;

    logic  valid;
    logic  ready;
    t_temp present_temp;
    t_drive pid_drive;
    t_time now_ms;
    logic  start_level;
    logic  select_top;

    modport source (output valid, present_temp, pid_drive, now_ms, start_level,
                    select_top, input ready);
    modport sink   (input valid, present_temp, pid_drive, now_ms, start_level,
                    select_top, output ready);
endinterface

interface tcs_out_if;
    import tcs_pkg::*;

    logic   valid;
    logic   ready;
    t_temp  setpoint;
    t_duty  heater_duty;
    t_duty  fan_duty;
    t_duty  cooler_fan_duty;
    t_duty  cooler_duty;
    logic   hold_done;
    t_phase phase;
    t_count cycles_done;

    modport source (output valid, setpoint, heater_duty, fan_duty, cooler_fan_duty,
                    cooler_duty, hold_done, phase, cycles_done, input ready);
    modport sink   (input valid, setpoint, heater_duty, fan_duty, cooler_fan_duty,
                    cooler_duty, hold_done, phase, cycles_done, output ready);
endinterface

interface tcs_cfg_if;
    import tcs_pkg::*;

    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/thermal_cycle_sequencer_top.sv
// ----------------------------------------------------------------------------
// Thermal cycle sequencer
// Soak, top/bottom cycling and final action sequencing with duty outputs.
// ----------------------------------------------------------------------------
// Each input word is one control tick and gives exactly one result word. A
// tick is captured in an input register; when the output register is empty or
// being taken, one pass of compare and subtract logic against the sequencer
// state produces the result word, which is loaded into the output register
// while the state updates. The block therefore takes one word per clock cycle
// when the sink keeps up. The rate is set by the single registered pass
// between the input and output registers; the output register lets a new word
// be taken while a result waits. The configuration channel is always ready;
// the user must write it only while the block is idle, which the block itself
// does not enforce. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module thermal_cycle_sequencer_top #(
    parameter int HEATER_KEEP_DUTY = 20,
    parameter int COOLER_DUTY      = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcs_in_if.sink        i_in,
    tcs_out_if.source     o_out,
    tcs_cfg_if.sink       i_cfg
);
    import tcs_pkg::*;

    localparam t_duty KEEP_DUTY = t_duty'(HEATER_KEEP_DUTY);
    localparam t_duty COOL_DUTY = t_duty'(COOLER_DUTY);

    // Configuration registers.
    t_temp  r_base_temp, r_top_temp, r_bottom_temp;
    t_hold  r_base_hold, r_top_hold, r_bottom_hold;
    t_count r_cycle_target;
    t_mode  r_mode;

    // Input register.
    logic   r_in_valid;
    t_temp  r_in_temp;
    t_drive r_in_drive;
    t_time  r_in_now;
    logic   r_in_start;
    logic   r_in_sel_top;

    // Sequencer state.
    logic   r_base_finished, n_base_finished;
    logic   r_heading_up, n_heading_up;
    t_count r_cycle_count, n_cycle_count;
    logic   r_holding, n_holding;
    t_time  r_hold_start, n_hold_start;
    t_temp  r_setpoint, n_setpoint;
    t_duty  r_heater, n_heater;
    t_duty  r_fan, n_fan;
    logic   r_cooler_on, n_cooler_on;

    // Output register.
    logic   r_out_valid;
    logic   r_out_done;
    t_phase r_out_phase;

    logic   advance;
    logic   n_done;
    t_phase n_phase;

    // Phase selection and working signals of the pass.
    logic   run_en;
    t_temp  run_target;
    logic   run_upward;
    t_hold  run_hold;
    logic   reached;
    logic   hold_over;
    t_time  elapsed;
    logic   drive_en;
    logic   cool_en;
    logic [DRIVE_W-1:0] drive_mag;

    // The input stage moves whenever the output register is empty or being
    // taken in the same cycle.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_temp    <= RST_BASE_TEMP;
            r_top_temp     <= RST_TOP_TEMP;
            r_bottom_temp  <= RST_BOTTOM_TEMP;
            r_base_hold    <= RST_HOLD_MS;
            r_top_hold     <= RST_HOLD_MS;
            r_bottom_hold  <= RST_HOLD_MS;
            r_cycle_target <= RST_CYCLE_TARGET;
            r_mode         <= RST_CONTROL_MODE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BASE_TEMP:      r_base_temp    <= t_temp'(i_cfg.data[TEMP_W-1:0]);
                CFG_TOP_TEMP:       r_top_temp     <= t_temp'(i_cfg.data[TEMP_W-1:0]);
                CFG_BOTTOM_TEMP:    r_bottom_temp  <= t_temp'(i_cfg.data[TEMP_W-1:0]);
                CFG_BASE_HOLD_MS:   r_base_hold    <= i_cfg.data[HOLD_W-1:0];
                CFG_TOP_HOLD_MS:    r_top_hold     <= i_cfg.data[HOLD_W-1:0];
                CFG_BOTTOM_HOLD_MS: r_bottom_hold  <= i_cfg.data[HOLD_W-1:0];
                CFG_CYCLE_TARGET:   r_cycle_target <= i_cfg.data[COUNT_W-1:0];
                CFG_CONTROL_MODE:   r_mode         <= i_cfg.data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_temp    <= i_in.present_temp;
            r_in_drive   <= i_in.pid_drive;
            r_in_now     <= i_in.now_ms;
            r_in_start   <= i_in.start_level;
            r_in_sel_top <= i_in.select_top;
        end
    end

    // Choose the running phase: none in manual mode or with start released, else
    // base soak while it is enabled and unfinished, then top or bottom while
    // cycles remain, then the final action. The base target is always approached upward.
    always_comb begin
        run_en     = 1'b0;
        run_target = r_base_temp;
        run_upward = 1'b1;
        run_hold   = r_base_hold;
        n_phase    = PH_FINAL;
        if (r_mode[3]) begin
            n_phase = PH_MANUAL;
        end else if (!r_in_start) begin
            n_phase = r_mode[0] ? PH_BASE : PH_TOP;
        end else if (r_mode[0] && !r_base_finished) begin
            run_en  = 1'b1;
            n_phase = PH_BASE;
        end else if (r_cycle_count < r_cycle_target) begin
            run_en = 1'b1;
            if (r_heading_up) begin
                run_target = r_top_temp;
                run_hold   = r_top_hold;
                n_phase    = PH_TOP;
            end else begin
                run_target = r_bottom_temp;
                run_upward = 1'b0;
                run_hold   = r_bottom_hold;
                n_phase    = PH_BOTTOM;
            end
        end
    end

    assign reached   = run_upward ? (r_in_temp >= run_target) : (r_in_temp <= run_target);
    // The hold time is measured modulo 2^32, so timestamp wrap is harmless.
    assign elapsed   = r_in_now - r_hold_start;
    assign hold_over = elapsed >= {{(TIME_W-HOLD_W){1'b0}}, run_hold};
    // Two's complement negation of the drive; only the most negative code
    // sets the top bit, and that case saturates the fan at full duty.
    assign drive_mag = ~r_in_drive + 1'b1;

    always_comb begin
        n_base_finished = r_base_finished;
        n_heading_up    = r_heading_up;
        n_cycle_count   = r_cycle_count;
        n_holding       = r_holding;
        n_hold_start    = r_hold_start;
        n_setpoint      = r_setpoint;
        n_heater        = r_heater;
        n_fan           = r_fan;
        n_cooler_on     = r_cooler_on;
        n_done          = 1'b0;
        drive_en        = 1'b0;
        cool_en         = 1'b0;

        if (r_mode[3]) begin
            // Manual mode leaves the sequencer alone and follows the switch.
            n_setpoint = r_in_sel_top ? r_top_temp : r_bottom_temp;
            drive_en   = 1'b1;
            cool_en    = !r_in_sel_top;
        end else if (!r_in_start) begin
            n_cycle_count   = '0;
            n_heading_up    = 1'b1;
            n_base_finished = 1'b0;
        end else if (run_en) begin
            n_setpoint = run_target;
            drive_en   = 1'b1;
            if (!r_holding) begin
                // Approach with the cooler allowed; the crossing tick starts
                // the hold, which is first checked on the following tick.
                cool_en = 1'b1;
                if (reached) begin
                    n_hold_start = r_in_now;
                    n_holding    = 1'b1;
                end
            end else if (hold_over) begin
                n_holding = 1'b0;
                n_done    = 1'b1;
                if (n_phase == PH_BASE) begin
                    n_base_finished = 1'b1;
                end else if (n_phase == PH_TOP) begin
                    n_heading_up = 1'b0;
                end else begin
                    n_heading_up  = 1'b1;
                    n_cycle_count = r_cycle_count + 1'b1;
                end
            end
        end else begin
            case (r_mode[2:1])
                FIN_HOLD_BASE: begin
                    n_setpoint = r_base_temp;
                    drive_en   = 1'b1;
                end
                FIN_HOLD_BOTTOM: begin
                    n_setpoint = r_bottom_temp;
                    drive_en   = 1'b1;
                end
                FIN_HOLD_TOP: begin
                    n_setpoint = r_top_temp;
                    drive_en   = 1'b1;
                end
                default: begin
                    // All off keeps the setpoint.
                    n_heater    = DUTY_OFF;
                    n_fan       = DUTY_OFF;
                    n_cooler_on = 1'b0;
                end
            endcase
        end

        // Drive stage: a positive drive heats, a negative one runs the fan,
        // keeps a small heater duty and updates the cooler.
        if (drive_en) begin
            if (!r_in_drive[DRIVE_W-1]) begin
                n_heater = r_in_drive[DUTY_W-1:0];
                n_fan    = DUTY_OFF;
            end else begin
                n_heater    = KEEP_DUTY;
                n_fan       = drive_mag[DRIVE_W-1] ? DUTY_FULL : drive_mag[DUTY_W-1:0];
                n_cooler_on = cool_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_finished <= 1'b0;
            r_heading_up    <= 1'b1;
            r_cycle_count   <= '0;
            r_holding       <= 1'b0;
            r_hold_start    <= '0;
            r_setpoint      <= RST_SETPOINT;
            r_heater        <= DUTY_OFF;
            r_fan           <= DUTY_OFF;
            r_cooler_on     <= 1'b0;
        end else if (advance) begin
            r_base_finished <= n_base_finished;
            r_heading_up    <= n_heading_up;
            r_cycle_count   <= n_cycle_count;
            r_holding       <= n_holding;
            r_hold_start    <= n_hold_start;
            r_setpoint      <= n_setpoint;
            r_heater        <= n_heater;
            r_fan           <= n_fan;
            r_cooler_on     <= n_cooler_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_done  <= n_done;
            r_out_phase <= n_phase;
        end
    end

    // The duty and count fields are the state registers themselves, which
    // only change when a new result is loaded.
    assign o_out.valid           = r_out_valid;
    assign o_out.setpoint        = r_setpoint;
    assign o_out.heater_duty     = r_heater;
    assign o_out.fan_duty        = r_fan;
    assign o_out.cooler_fan_duty = r_cooler_on ? DUTY_FULL : DUTY_OFF;
    assign o_out.cooler_duty     = r_cooler_on ? COOL_DUTY : DUTY_OFF;
    assign o_out.hold_done       = r_out_done;
    assign o_out.phase           = r_out_phase;
    assign o_out.cycles_done     = r_cycle_count;

    // A hold can only end from the holding state.
    a_done_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_done) |-> r_holding)
        else $error("hold ended without an active hold");

    // Manual ticks never report a finished hold.
    a_manual_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_mode[3]) |=> !r_out_done)
        else $error("hold_done set in manual mode");

    // A released start button restarts the cycle count.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_mode[3] && !r_in_start) |=> (r_cycle_count == '0) && r_heading_up)
        else $error("start release did not restart the sequence");

endmodule
